// ===== design/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg: shared types and constants of the particle pool update block
// Register indexes, field widths and the request payload structures.
// ----------------------------------------------------------------------------
`default_nettype none
package ppu_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LIFE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_ACCEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXT_FORCE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_RANGE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_RATE    = 3'd7;

    localparam logic [31:0] ONE_Q16 = 32'd65536;

    typedef struct packed {
        logic [15:0]        tick_seconds;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] rotation_deg;
        logic signed [31:0] life_left;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic [15:0]        new_size;
        logic signed [31:0] new_rotation;
        logic signed [31:0] new_life;
        logic [31:0]        new_color;
    } t_out;

    typedef struct packed {
        logic [31:0] start_color;
        logic [31:0] end_color;
        logic [31:0] inv_max_life;
        logic [31:0] base_speed;
        logic [31:0] speed_accel;
        logic [31:0] external_force;
        logic [31:0] size_range;
        logic [31:0] rotation_rate;
    } t_cfg;

    // Blend of two 16-bit values by a 17-bit weight t (0..65536), floor.
    function automatic logic [15:0] blend16(input logic [15:0] a, input logic [15:0] b,
                                            input logic [16:0] t);
        logic [33:0] s;
        s = 34'(a) * 34'(17'h10000 - t) + 34'(b) * 34'(t);
        return s[31:16];
    endfunction

endpackage
`default_nettype wire

// ===== design/ppu_if.sv =====
// ----------------------------------------------------------------------------
// ppu_in_if / ppu_out_if / ppu_cfg_if: valid-ready channels of the block
// Each carries valid, ready and a payload, with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none
interface ppu_in_if;
    logic           valid;
    logic           ready;
    ppu_pkg::t_in   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppu_out_if;
    logic           valid;
    logic           ready;
    ppu_pkg::t_out  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ppu_pkg::CFG_IDX_W-1:0]   index;
    logic [31:0]                     wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== design/ppu_regs.sv =====
// ----------------------------------------------------------------------------
// ppu_regs: configuration register file
// Holds the eight setup registers; writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_regs (
    input  wire            i_clk,
    input  wire            i_rst_n,
    ppu_cfg_if.sink        cfg,
    output ppu_pkg::t_cfg  o_cfg
);
    ppu_pkg::t_cfg r_cfg;

    assign cfg.ready = 1'b1;
    assign o_cfg     = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_color    <= 32'hFFFF_FFFF;
            r_cfg.end_color      <= 32'd0;
            r_cfg.inv_max_life   <= ppu_pkg::ONE_Q16;
            r_cfg.base_speed     <= ppu_pkg::ONE_Q16;
            r_cfg.speed_accel    <= 32'd0;
            r_cfg.external_force <= 32'd0;
            r_cfg.size_range     <= 32'd0;
            r_cfg.rotation_rate  <= 32'd0;
        end else if (cfg.valid) begin
            unique case (cfg.index)
                ppu_pkg::REG_START_COLOR: r_cfg.start_color    <= cfg.wdata;
                ppu_pkg::REG_END_COLOR:   r_cfg.end_color      <= cfg.wdata;
                ppu_pkg::REG_INV_LIFE:    r_cfg.inv_max_life   <= cfg.wdata;
                ppu_pkg::REG_BASE_SPEED:  r_cfg.base_speed     <= cfg.wdata;
                ppu_pkg::REG_SPEED_ACCEL: r_cfg.speed_accel    <= cfg.wdata;
                ppu_pkg::REG_EXT_FORCE:   r_cfg.external_force <= cfg.wdata;
                ppu_pkg::REG_SIZE_RANGE:  r_cfg.size_range     <= cfg.wdata;
                ppu_pkg::REG_ROT_RATE:    r_cfg.rotation_rate  <= cfg.wdata;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/ppu_pipe.sv =====
// ----------------------------------------------------------------------------
// ppu_pipe: six-stage arithmetic pipeline of the particle update
// At most one multiply level per stage; a common enable stalls all stages at once.
// ----------------------------------------------------------------------------
`default_nettype none
module ppu_pipe (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_en,
    input  wire            i_valid,
    input  ppu_pkg::t_in   i_data,
    input  ppu_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output ppu_pkg::t_out  o_data
);
    // Stage 1: life times reciprocal (life is known non-negative).
    logic               r1_v;
    ppu_pkg::t_in       r1_d;
    logic [63:0]        r1_prod;
    // Stage 2: age fraction.
    logic               r2_v;
    ppu_pkg::t_in       r2_d;
    logic [16:0]        r2_t;
    // Stage 3: blends, accel product, rotation product.
    logic               r3_v;
    ppu_pkg::t_in       r3_d;
    logic [31:0]        r3_color;
    logic [15:0]        r3_size;
    logic signed [49:0] r3_acc;
    logic signed [48:0] r3_rotp;
    // Stage 4: clamped speed and summed rotation.
    logic               r4_v;
    ppu_pkg::t_in       r4_d;
    logic [31:0]        r4_color;
    logic [15:0]        r4_size;
    logic [30:0]        r4_speed;
    logic signed [31:0] r4_rot;
    // Stage 5: speed times direction plus force.
    logic               r5_v;
    ppu_pkg::t_in       r5_d;
    logic [31:0]        r5_color;
    logic [15:0]        r5_size;
    logic signed [31:0] r5_rot;
    logic signed [47:0] r5_sx;
    logic signed [47:0] r5_sy;
    // Stage 6: step times tick, saturate.
    logic               r6_v;
    ppu_pkg::t_out      r6_o;

    logic [16:0]        n_t;
    logic [31:0]        n_color;
    logic signed [48:0] n_speed;
    logic signed [63:0] n_mx;
    logic signed [63:0] n_my;
    logic signed [65:0] n_px;
    logic signed [65:0] n_py;
    logic signed [31:0] n_satx;
    logic signed [31:0] n_saty;

    always_comb begin
        n_t = (r1_prod[63:16] >= 48'h10000) ? 17'd0 : 17'h10000 - 17'(r1_prod[32:16]);
        for (int k = 0; k < 4; k++) begin
            n_color[8*k +: 8] = 8'(ppu_pkg::blend16({8'd0, i_cfg.start_color[8*k +: 8]},
                                                   {8'd0, i_cfg.end_color[8*k +: 8]}, r2_t));
        end
        n_speed = 49'($signed(i_cfg.base_speed)) + 49'(r3_acc >>> 16);
        n_mx = $signed({1'b0, r4_speed}) * r4_d.vel_x;
        n_my = $signed({1'b0, r4_speed}) * r4_d.vel_y;
        n_px = 66'(r5_sx) * 66'($signed({1'b0, r5_d.tick_seconds}));
        n_py = 66'(r5_sy) * 66'($signed({1'b0, r5_d.tick_seconds}));
        n_px = 66'(r5_d.pos_x) + (n_px >>> 16);
        n_py = 66'(r5_d.pos_y) + (n_py >>> 16);
        n_satx = (n_px > 66'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (n_px < -66'sh8000_0000) ? 32'sh8000_0000 : n_px[31:0];
        n_saty = (n_py > 66'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (n_py < -66'sh8000_0000) ? 32'sh8000_0000 : n_py[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0;
            r4_v <= 1'b0; r5_v <= 1'b0; r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid && !i_data.life_left[31];
            r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v; r5_v <= r4_v; r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= i_data;
            r1_prod <= 64'(i_data.life_left[30:0]) * 64'(i_cfg.inv_max_life);

            r2_d <= r1_d;
            r2_t <= n_t;

            r3_d     <= r2_d;
            r3_color <= n_color;
            r3_size  <= ppu_pkg::blend16(i_cfg.size_range[31:16], i_cfg.size_range[15:0], r2_t);
            r3_acc   <= $signed(i_cfg.speed_accel) * $signed({1'b0, r2_t});
            r3_rotp  <= $signed({1'b0, r2_d.tick_seconds}) * $signed(i_cfg.rotation_rate);

            r4_d     <= r3_d;
            r4_color <= r3_color;
            r4_size  <= r3_size;
            r4_speed <= n_speed[48] ? 31'd0 :
                        (n_speed > 49'sh7FFF_FFFF) ? 31'h7FFF_FFFF : n_speed[30:0];
            r4_rot   <= r3_d.rotation_deg + 32'(r3_rotp >>> 16);

            r5_d     <= r4_d;
            r5_color <= r4_color;
            r5_size  <= r4_size;
            r5_rot   <= r4_rot;
            r5_sx    <= 48'(n_mx >>> 16) +
                        48'($signed(i_cfg.external_force[31:16])) * 48'sd256;
            r5_sy    <= 48'(n_my >>> 16) +
                        48'($signed(i_cfg.external_force[15:0])) * 48'sd256;

            r6_o.new_pos_x    <= n_satx;
            r6_o.new_pos_y    <= n_saty;
            r6_o.out_vel_x    <= r5_d.vel_x;
            r6_o.out_vel_y    <= r5_d.vel_y;
            r6_o.new_size     <= r5_size;
            r6_o.new_rotation <= r5_rot;
            r6_o.new_life     <= r5_d.life_left - 32'(r5_d.tick_seconds);
            r6_o.new_color    <= r5_color;
        end
    end

    assign o_valid = r6_v;
    assign o_data  = r6_o;
endmodule
`default_nettype wire

// ===== design/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update: streaming per-particle update with pool compaction
// ----------------------------------------------------------------------------
// One particle request enters on the input channel per cycle while ready, with
// the frame tick. A particle whose remaining life is negative is dropped, so
// the surviving particles leave the output channel in their input order.
// Live particles get the age fraction from the reciprocal-of-life register,
// a blended color and size, a speed clamped at zero, and updated position
// (saturating), rotation (wrapping) and life.
// A result request comes from the last pipeline stage; throughput is one
// particle per cycle as long as the receiver keeps taking results.
// The setup registers are written through the configuration channel, which
// is always ready; write them only while no particle is in flight.
// Synchronous reset empties the pipeline and loads the register defaults.
// When the receiver stalls, the whole pipeline holds in place; input ready
// stays high only while the output stage is empty or being drained, so it
// drops as soon as a result waits, even if earlier stages are empty.
// ----------------------------------------------------------------------------
`default_nettype none
module particle_pool_update (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ppu_in_if.sink     in_ch,
    ppu_cfg_if.sink    cfg_ch,
    ppu_out_if.source  out_ch
);
    ppu_pkg::t_cfg w_cfg;
    logic          w_en;

    ppu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_ch),
        .o_cfg   (w_cfg)
    );

    // Pipeline advances when the last stage is empty or being taken.
    assign w_en        = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = w_en;

    ppu_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (in_ch.valid),
        .i_data  (in_ch.data),
        .i_cfg   (w_cfg),
        .o_valid (out_ch.valid),
        .o_data  (out_ch.data)
    );
endmodule
`default_nettype wire
